[design/stbd_pkg.sv]
// Shared types, constants and helper functions of the saved-track block decoder.
package stbd_pkg;

   localparam int BlockBytesDefault = 97;
   localparam int IdxW = 7;
   localparam int RecBytes = 12;
   localparam int WinBytes = RecBytes + 1;
   localparam int TailReads = 4;
   localparam int QueueDepth = 2;

   localparam logic [14:0] EleScale = 15'd31500;
   localparam logic [31:0] EleOffsetQ16 = 32'd98304000;
   localparam logic [23:0] FoldLimit = 24'd8388608;
   localparam logic [24:0] FoldSpan = 25'd16777216;
   localparam logic [31:0] TimeOffset = 32'd631065600;
   localparam logic [7:0] Div12Recip = 8'd171;
   localparam int Div12Shift = 11;

   typedef logic [IdxW-1:0] idx_type;

   typedef struct packed {
      logic bank;
      idx_type n;
      logic eot;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_NEXT,
      ST_READ,
      ST_LAST,
      ST_CALC,
      ST_EMIT,
      ST_TAIL_SETUP,
      ST_TAIL_READ,
      ST_TAIL_LAST,
      ST_TAIL_CALC,
      ST_TAIL_EMIT,
      ST_DONE
   } state_type;

   // Exact floor(i / 12) for every 7-bit index.
   function automatic logic [3:0] div12(input idx_type i);
      logic [14:0] prod;
      prod = 15'(i) * 15'(Div12Recip);
      return 4'(prod >> Div12Shift);
   endfunction

   function automatic logic [24:0] fold24(input logic [23:0] v);
      logic [24:0] r;
      if (v > FoldLimit) begin
         r = 25'(v) - FoldSpan;
      end else begin
         r = 25'(v);
      end
      return r;
   endfunction

   function automatic logic [7:0] pick_byte(input logic [7:0] lo, input logic [7:0] hi,
                                            input logic [2:0] sh);
      logic [15:0] pair;
      pair = {hi, lo} >> sh;
      return pair[7:0];
   endfunction

endpackage

[design/stbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module stbd_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/stbd_front.sv]
// Front end: accepts track bytes, fills the current buffer bank and posts block jobs.
module stbd_front #(
   parameter int BlockBytes = stbd_pkg::BlockBytesDefault,
   parameter int CntW = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_end_of_block,
   input  logic                req_end_of_track,
   output logic                ram_wr_en,
   output logic [CntW:0]       ram_wr_addr,
   output logic [7:0]          ram_wr_data,
   output logic                job_push,
   output stbd_pkg::job_type   job_data,
   input  logic                bank_free
);

   stbd_pkg::idx_type count_ff, count_in;
   logic              wbank_ff, wbank_in;
   logic [1:0]        busy_ff, busy_in;
   logic              accept;
   logic              room;

   always_comb begin
      accept = req_valid && !req_stall;
      room = count_ff < stbd_pkg::IdxW'(BlockBytes);

      ram_wr_en = accept && room;
      ram_wr_addr = {wbank_ff, count_ff[CntW-1:0]};
      ram_wr_data = req_data_byte;

      job_push = accept && req_end_of_block;
      job_data.bank = wbank_ff;
      job_data.n = count_ff + stbd_pkg::IdxW'(room);
      job_data.eot = req_end_of_track;

      count_in = count_ff;
      if (accept) begin
         if (req_end_of_block) begin
            count_in = '0;
         end else if (room) begin
            count_in = count_ff + stbd_pkg::IdxW'(1);
         end
      end
      wbank_in = wbank_ff ^ job_push;
      busy_in = busy_ff + 2'(job_push) - 2'(bank_free);
   end

   assign req_stall = busy_ff == 2'(stbd_pkg::QueueDepth);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wbank_ff <= 1'b0;
         busy_ff <= '0;
      end else begin
         count_ff <= count_in;
         wbank_ff <= wbank_in;
         busy_ff <= busy_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_busy_bounded: assert property (@(posedge clock) disable iff (reset)
      busy_ff <= 2'(stbd_pkg::QueueDepth))
      else $error("more blocks pending than buffer banks");

   a_free_when_busy: assert property (@(posedge clock) disable iff (reset)
      bank_free |-> busy_ff != 2'd0)
      else $error("bank released while no block was pending");
`endif

endmodule

[design/stbd_queue.sv]
// Two-entry job queue between the front end and the back end.
module stbd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  stbd_pkg::job_type push_data,
   input  logic              pop,
   output logic              empty,
   output stbd_pkg::job_type head
);

   stbd_pkg::job_type entry_ff [stbd_pkg::QueueDepth];
   stbd_pkg::job_type entry_in [stbd_pkg::QueueDepth];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;

   always_comb begin
      entry_in = entry_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = push_data;
      end
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   assign empty = cnt_ff == 2'd0;
   assign head = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[design/stbd_back.sv]
// Back end: descrambles a stored block record by record and emits track points.
module stbd_back #(
   parameter int CntW = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_empty,
   input  stbd_pkg::job_type   job_head,
   output logic                job_pop,
   output logic [CntW:0]       ram_rd_addr,
   input  logic [7:0]          ram_rd_data,
   output logic                bank_free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [24:0]  rsp_latitude_raw,
   output logic signed [24:0]  rsp_longitude_raw,
   output logic signed [31:0]  rsp_elevation_q16,
   output logic [31:0]         rsp_time_unix,
   output logic                rsp_closing_point,
   output logic                rsp_last
);

   localparam int IdxW1 = stbd_pkg::IdxW + 1;
   localparam int RecBytes = stbd_pkg::RecBytes;
   localparam int WinBytes = stbd_pkg::WinBytes;

   stbd_pkg::state_type state_ff, state_in;
   stbd_pkg::job_type   job_ff, job_in;
   logic [3:0]          nrec_ff, nrec_in;
   logic [3:0]          pass_ff, pass_in;
   logic [3:0]          rec_ff, rec_in;
   logic [3:0]          rd_cnt_ff, rd_cnt_in;
   logic                rd_pend_ff, rd_pend_in;
   logic                rd_zero_ff, rd_zero_in;
   logic [7:0]          win_ff [WinBytes];
   logic [7:0]          win_in [WinBytes];
   logic signed [24:0]  lat_ff, lat_in;
   logic signed [24:0]  lon_ff, lon_in;
   logic [31:0]         time_ff, time_in;
   logic [30:0]         prod_ff, prod_in;
   logic signed [24:0]  prev_lat_ff, prev_lat_in;
   logic signed [24:0]  prev_lon_ff, prev_lon_in;
   logic [31:0]         prev_time_ff, prev_time_in;
   logic                first_ff, first_in;
   logic [IdxW1-1:0]    a_lo_ff, a_lo_in;
   logic [IdxW1-1:0]    a_hi_ff, a_hi_in;
   logic [2:0]          sh_lo_ff, sh_lo_in;
   logic [2:0]          sh_hi_ff, sh_hi_in;
   logic                lo_ok_ff, lo_ok_in;
   logic                out_valid_ff, out_valid_in;
   logic signed [24:0]  out_lat_ff, out_lat_in;
   logic signed [24:0]  out_lon_ff, out_lon_in;
   logic signed [31:0]  out_ele_ff, out_ele_in;
   logic [31:0]         out_time_ff, out_time_in;
   logic                out_closing_ff, out_closing_in;
   logic                out_last_ff, out_last_in;

   logic                out_free;
   logic                rec_go;
   logic                tail_go;
   logic                out_load;
   logic                issue;
   logic [IdxW1-1:0]    rd_idx;
   logic [7:0]          fb [RecBytes];
   logic [7:0]          tail_hi;
   logic [7:0]          tail_lo;
   stbd_pkg::idx_type   c_val;
   stbd_pkg::idx_type   i_hi;
   stbd_pkg::idx_type   i_lo;
   logic [3:0]          d_hi;
   logic [3:0]          d_lo;
   logic [3:0]          k_hi;
   logic [3:0]          k_lo;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign rec_go = (state_ff == stbd_pkg::ST_EMIT) && (first_ff || out_free);
   assign tail_go = (state_ff == stbd_pkg::ST_TAIL_EMIT) && out_free;
   assign out_load = (rec_go && !first_ff) || tail_go;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stbd_pkg::ST_IDLE: begin
            if (!job_empty) begin
               state_in = stbd_pkg::ST_SETUP;
            end
         end
         stbd_pkg::ST_SETUP: state_in = stbd_pkg::ST_NEXT;
         stbd_pkg::ST_NEXT: begin
            if (rec_ff < nrec_ff) begin
               state_in = stbd_pkg::ST_READ;
            end else if (job_ff.eot) begin
               state_in = stbd_pkg::ST_TAIL_SETUP;
            end else begin
               state_in = stbd_pkg::ST_DONE;
            end
         end
         stbd_pkg::ST_READ: begin
            if (rd_cnt_ff == 4'(RecBytes)) begin
               state_in = stbd_pkg::ST_LAST;
            end
         end
         stbd_pkg::ST_LAST: state_in = stbd_pkg::ST_CALC;
         stbd_pkg::ST_CALC: state_in = stbd_pkg::ST_EMIT;
         stbd_pkg::ST_EMIT: begin
            if (rec_go) begin
               state_in = stbd_pkg::ST_NEXT;
            end
         end
         stbd_pkg::ST_TAIL_SETUP: state_in = stbd_pkg::ST_TAIL_READ;
         stbd_pkg::ST_TAIL_READ: begin
            if (rd_cnt_ff == 4'(stbd_pkg::TailReads - 1)) begin
               state_in = stbd_pkg::ST_TAIL_LAST;
            end
         end
         stbd_pkg::ST_TAIL_LAST: state_in = stbd_pkg::ST_TAIL_CALC;
         stbd_pkg::ST_TAIL_CALC: state_in = stbd_pkg::ST_TAIL_EMIT;
         stbd_pkg::ST_TAIL_EMIT: begin
            if (tail_go) begin
               state_in = stbd_pkg::ST_DONE;
            end
         end
         stbd_pkg::ST_DONE: state_in = stbd_pkg::ST_IDLE;
         default: state_in = stbd_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      job_in = job_ff;
      nrec_in = nrec_ff;
      pass_in = pass_ff;
      rec_in = rec_ff;
      rd_cnt_in = rd_cnt_ff;
      lat_in = lat_ff;
      lon_in = lon_ff;
      time_in = time_ff;
      prod_in = prod_ff;
      prev_lat_in = prev_lat_ff;
      prev_lon_in = prev_lon_ff;
      prev_time_in = prev_time_ff;
      first_in = first_ff;
      a_lo_in = a_lo_ff;
      a_hi_in = a_hi_ff;
      sh_lo_in = sh_lo_ff;
      sh_hi_in = sh_hi_ff;
      lo_ok_in = lo_ok_ff;
      out_lat_in = out_lat_ff;
      out_lon_in = out_lon_ff;
      out_ele_in = out_ele_ff;
      out_time_in = out_time_ff;
      out_closing_in = out_closing_ff;
      out_last_in = out_last_ff;

      job_pop = (state_ff == stbd_pkg::ST_IDLE) && !job_empty;
      bank_free = state_ff == stbd_pkg::ST_DONE;
      issue = (state_ff == stbd_pkg::ST_READ) || (state_ff == stbd_pkg::ST_TAIL_READ);

      // Record r needs raw bytes from 12r + r/8, shifted right by r mod 8 bits.
      rd_idx = IdxW1'(rec_ff) * IdxW1'(RecBytes) + IdxW1'(rec_ff[3]) + IdxW1'(rd_cnt_ff);
      if (state_ff == stbd_pkg::ST_TAIL_READ) begin
         case (rd_cnt_ff[1:0])
            2'd0: rd_idx = a_lo_ff;
            2'd1: rd_idx = a_lo_ff + IdxW1'(1);
            2'd2: rd_idx = a_hi_ff;
            default: rd_idx = a_hi_ff + IdxW1'(1);
         endcase
      end
      ram_rd_addr = {job_ff.bank, rd_idx[CntW-1:0]};
      rd_zero_in = rd_idx >= IdxW1'(job_ff.n);
      rd_pend_in = issue;
      if (issue) begin
         rd_cnt_in = rd_cnt_ff + 4'd1;
      end

      win_in = win_ff;
      if (rd_pend_ff) begin
         for (int b = 0; b < WinBytes - 1; b++) begin
            win_in[b] = win_ff[b + 1];
         end
         win_in[WinBytes - 1] = rd_zero_ff ? 8'd0 : ram_rd_data;
      end

      for (int b = 0; b < RecBytes; b++) begin
         fb[b] = stbd_pkg::pick_byte(win_ff[b], win_ff[b + 1], rec_ff[2:0]);
      end
      tail_hi = stbd_pkg::pick_byte(win_ff[WinBytes - 2], win_ff[WinBytes - 1], sh_hi_ff);
      tail_lo = lo_ok_ff ?
                stbd_pkg::pick_byte(win_ff[WinBytes - 4], win_ff[WinBytes - 3], sh_lo_ff) :
                8'd0;

      c_val = (job_ff.n > stbd_pkg::IdxW'(RecBytes)) ?
              job_ff.n - stbd_pkg::IdxW'(1) : job_ff.n;
      i_hi = c_val - stbd_pkg::IdxW'(1);
      i_lo = c_val - stbd_pkg::IdxW'(2);
      d_hi = stbd_pkg::div12(i_hi);
      d_lo = stbd_pkg::div12(i_lo);
      k_hi = (d_hi > pass_ff) ? pass_ff : d_hi;
      k_lo = (d_lo > pass_ff) ? pass_ff : d_lo;

      unique case (state_ff)
         stbd_pkg::ST_IDLE: begin
            if (!job_empty) begin
               job_in = job_head;
            end
         end
         stbd_pkg::ST_SETUP: begin
            nrec_in = stbd_pkg::div12(job_ff.n - stbd_pkg::IdxW'(1));
            pass_in = (job_ff.n >= stbd_pkg::IdxW'(2)) ?
                      stbd_pkg::div12(job_ff.n - stbd_pkg::IdxW'(2)) : 4'd0;
            rec_in = '0;
         end
         stbd_pkg::ST_NEXT: rd_cnt_in = '0;
         stbd_pkg::ST_CALC: begin
            prod_in = 31'({fb[1], fb[0]}) * 31'(stbd_pkg::EleScale);
            lat_in = $signed(stbd_pkg::fold24({fb[4], fb[3], fb[2]}));
            lon_in = $signed(stbd_pkg::fold24({fb[7], fb[6], fb[5]}));
            time_in = {fb[11], fb[10], fb[9], fb[8]} + stbd_pkg::TimeOffset;
         end
         stbd_pkg::ST_EMIT: begin
            if (rec_go) begin
               prev_lat_in = lat_ff;
               prev_lon_in = lon_ff;
               prev_time_in = time_ff;
               first_in = 1'b0;
               rec_in = rec_ff + 4'd1;
            end
         end
         stbd_pkg::ST_TAIL_SETUP: begin
            a_hi_in = IdxW1'(i_hi) + IdxW1'(k_hi[3]);
            a_lo_in = IdxW1'(i_lo) + IdxW1'(k_lo[3]);
            sh_hi_in = k_hi[2:0];
            sh_lo_in = k_lo[2:0];
            lo_ok_in = c_val >= stbd_pkg::IdxW'(2);
            rd_cnt_in = '0;
         end
         stbd_pkg::ST_TAIL_CALC: begin
            prod_in = 31'({tail_hi, tail_lo}) * 31'(stbd_pkg::EleScale);
         end
         stbd_pkg::ST_TAIL_EMIT: begin
            if (tail_go) begin
               first_in = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (out_load) begin
         out_lat_in = prev_lat_ff;
         out_lon_in = prev_lon_ff;
         out_ele_in = $signed(32'(prod_ff) - stbd_pkg::EleOffsetQ16);
         out_time_in = prev_time_ff;
         out_closing_in = tail_go;
         out_last_in = tail_go || ((rec_ff + 4'd1 == nrec_ff) && !job_ff.eot);
      end
      out_valid_in = out_load || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      nrec_ff <= nrec_in;
      pass_ff <= pass_in;
      rec_ff <= rec_in;
      rd_cnt_ff <= rd_cnt_in;
      rd_zero_ff <= rd_zero_in;
      win_ff <= win_in;
      lat_ff <= lat_in;
      lon_ff <= lon_in;
      time_ff <= time_in;
      prod_ff <= prod_in;
      a_lo_ff <= a_lo_in;
      a_hi_ff <= a_hi_in;
      sh_lo_ff <= sh_lo_in;
      sh_hi_ff <= sh_hi_in;
      lo_ok_ff <= lo_ok_in;
      out_lat_ff <= out_lat_in;
      out_lon_ff <= out_lon_in;
      out_ele_ff <= out_ele_in;
      out_time_ff <= out_time_in;
      out_closing_ff <= out_closing_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         state_ff <= stbd_pkg::ST_IDLE;
         rd_pend_ff <= 1'b0;
         prev_lat_ff <= '0;
         prev_lon_ff <= '0;
         prev_time_ff <= '0;
         first_ff <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_pend_ff <= rd_pend_in;
         prev_lat_ff <= prev_lat_in;
         prev_lon_ff <= prev_lon_in;
         prev_time_ff <= prev_time_in;
         first_ff <= first_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_latitude_raw = out_lat_ff;
   assign rsp_longitude_raw = out_lon_ff;
   assign rsp_elevation_q16 = out_ele_ff;
   assign rsp_time_unix = out_time_ff;
   assign rsp_closing_point = out_closing_ff;
   assign rsp_last = out_last_ff;

`ifndef NO_ASSERTIONS
   a_closing_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_closing_ff |-> out_last_ff)
      else $error("closing point not flagged as last");

   a_window_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stbd_pkg::ST_CALC || state_ff == stbd_pkg::ST_TAIL_CALC) |-> !rd_pend_ff)
      else $error("field extraction while a read is still in flight");
`endif

endmodule

[design/saved_track_block_decoder_unit.sv]
// Top level of the saved-track block decoder: front end, job queue, buffer RAM, back end.
//
// The request channel takes one raw track byte per accepted request, with flags
// marking the last byte of a block and the last block of a track. Bytes beyond
// BLOCK_BYTES in one block are dropped. Requests are taken one per cycle into one
// of two buffer banks; req_stall rises only while both banks hold blocks that the
// back end has not yet finished.
// The back end walks a block one 12-byte record at a time: 13 buffer reads through
// the single RAM read port, then extract, scale and emit, so the RAM read port sets
// the sustained pace of a full block.
// Each point leaves through an output register; while rsp_stall is high the point
// holds and the back end waits, while the front end keeps filling the free bank.
// Reset clears the byte count, the bank and queue state, the held point (all zero)
// and marks the next record as the first of a track. Buffer contents are not
// cleared and need no clearing pass.
module saved_track_block_decoder_unit #(
   parameter int BLOCK_BYTES = stbd_pkg::BlockBytesDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_block,
   input  logic               req_end_of_track,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [24:0] rsp_latitude_raw,
   output logic signed [24:0] rsp_longitude_raw,
   output logic signed [31:0] rsp_elevation_q16,
   output logic [31:0]        rsp_time_unix,
   output logic               rsp_closing_point,
   output logic               rsp_last
);

   localparam int CntW = $clog2(BLOCK_BYTES + 1);
   localparam int RamDepth = 2 * (2 ** CntW);

   logic              ram_wr_en;
   logic [CntW:0]     ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic [CntW:0]     ram_rd_addr;
   logic [7:0]        ram_rd_data;
   logic              job_push;
   stbd_pkg::job_type job_wdata;
   logic              job_pop;
   logic              job_empty;
   stbd_pkg::job_type job_head;
   logic              bank_free;

   stbd_front #(
      .BlockBytes(BLOCK_BYTES),
      .CntW(CntW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_end_of_block(req_end_of_block),
      .req_end_of_track(req_end_of_track),
      .ram_wr_en(ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .job_push(job_push),
      .job_data(job_wdata),
      .bank_free(bank_free)
   );

   stbd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .push_data(job_wdata),
      .pop(job_pop),
      .empty(job_empty),
      .head(job_head)
   );

   stbd_ram #(
      .Width(8),
      .Depth(RamDepth)
   ) u_ram (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   stbd_back #(
      .CntW(CntW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .job_empty(job_empty),
      .job_head(job_head),
      .job_pop(job_pop),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data),
      .bank_free(bank_free),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_latitude_raw(rsp_latitude_raw),
      .rsp_longitude_raw(rsp_longitude_raw),
      .rsp_elevation_q16(rsp_elevation_q16),
      .rsp_time_unix(rsp_time_unix),
      .rsp_closing_point(rsp_closing_point),
      .rsp_last(rsp_last)
   );

endmodule

[tb/saved_track_block_decoder_checker.sv]
// Checker that predicts the decoded track points from accepted requests and compares results.
module saved_track_block_decoder_checker #(
   parameter int BLOCK_BYTES = stbd_pkg::BlockBytesDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_block,
   input  logic               req_end_of_track,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [24:0] rsp_latitude_raw,
   input  logic signed [24:0] rsp_longitude_raw,
   input  logic signed [31:0] rsp_elevation_q16,
   input  logic [31:0]        rsp_time_unix,
   input  logic               rsp_closing_point,
   input  logic               rsp_last,
   output int                 fail_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [24:0] lat;
      logic [24:0] lon;
      logic [31:0] ele;
      logic [31:0] tstamp;
      logic        closing;
      logic        last;
   } track_point_type;

   logic [7:0]      track_bytes [BLOCK_BYTES];
   int              fill_count;
   logic [24:0]     held_lat;
   logic [24:0]     held_lon;
   logic [31:0]     held_time;
   logic            first_rec;
   track_point_type expected_points [$];
   track_point_type want;
   int              errors = 0;

   function automatic logic [24:0] fold_coord(input logic [23:0] v);
      logic [24:0] r;
      if (v > stbd_pkg::FoldLimit) begin
         r = 25'(v) - stbd_pkg::FoldSpan;
      end else begin
         r = 25'(v);
      end
      return r;
   endfunction

   function automatic logic [31:0] scale_elevation(input logic [15:0] raw);
      longint e;
      e = longint'(raw) * longint'(stbd_pkg::EleScale) - longint'(stbd_pkg::EleOffsetQ16);
      return e[31:0];
   endfunction

   task automatic report(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] exp_val);
      if (got !== exp_val) begin
         report($sformatf("%s got 0x%08h, expected 0x%08h", name, got, exp_val));
      end
   endtask

   task automatic decode_track_byte(input logic [7:0] b, input logic eob, input logic eot_in);
      track_point_type pts [(BLOCK_BYTES - 1) / stbd_pkg::RecBytes + 1];
      int           n;
      int           nrec;
      int           p;
      int           c;
      int           k;
      logic [15:0]  ele;
      logic [23:0]  lat;
      logic [23:0]  lon;
      logic [31:0]  t;
      logic [7:0]   hi;
      logic [7:0]   lo;
      logic [7:0]   v;
      k = 0;
      if (fill_count < BLOCK_BYTES) begin
         track_bytes[fill_count] = b;
         fill_count++;
      end
      if (eob) begin
         n = fill_count;
         for (int s = stbd_pkg::RecBytes; s + 1 < n; s += stbd_pkg::RecBytes) begin
            for (int i = s; i < n; i++) begin
               v = track_bytes[i] >> 1;
               if (i + 1 < n) begin
                  v[7] = track_bytes[i + 1][0];
               end
               track_bytes[i] = v;
            end
         end
         nrec = (n - 1) / stbd_pkg::RecBytes;
         for (int r = 0; r < nrec; r++) begin
            p = r * stbd_pkg::RecBytes;
            ele = {track_bytes[p + 1], track_bytes[p]};
            lat = {track_bytes[p + 4], track_bytes[p + 3], track_bytes[p + 2]};
            lon = {track_bytes[p + 7], track_bytes[p + 6], track_bytes[p + 5]};
            t = {track_bytes[p + 11], track_bytes[p + 10], track_bytes[p + 9],
                 track_bytes[p + 8]};
            if (!first_rec) begin
               pts[k] = '{held_lat, held_lon, scale_elevation(ele), held_time, 1'b0, 1'b0};
               k++;
            end else begin
               first_rec = 1'b0;
            end
            held_lat = fold_coord(lat);
            held_lon = fold_coord(lon);
            held_time = t + stbd_pkg::TimeOffset;
         end
         if (eot_in) begin
            c = n;
            if (c > stbd_pkg::RecBytes) begin
               c--;
            end
            hi = (c >= 1) ? track_bytes[c - 1] : 8'h00;
            lo = (c >= 2) ? track_bytes[c - 2] : 8'h00;
            pts[k] = '{held_lat, held_lon, scale_elevation({hi, lo}), held_time, 1'b1, 1'b0};
            k++;
            first_rec = 1'b1;
         end
         for (int j = 0; j < k; j++) begin
            pts[j].last = (j == k - 1);
            expected_points.push_back(pts[j]);
         end
         fill_count = 0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill_count = 0;
         held_lat = '0;
         held_lon = '0;
         held_time = '0;
         first_rec = 1'b1;
         expected_points.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               report($sformatf("unexpected point lat %0d lon %0d time 0x%08h",
                                rsp_latitude_raw, rsp_longitude_raw, rsp_time_unix));
            end else begin
               want = expected_points.pop_front();
               check_field("latitude_raw", {7'b0, rsp_latitude_raw}, {7'b0, want.lat});
               check_field("longitude_raw", {7'b0, rsp_longitude_raw}, {7'b0, want.lon});
               check_field("elevation_q16", rsp_elevation_q16, want.ele);
               check_field("time_unix", rsp_time_unix, want.tstamp);
               check_field("closing_point", {31'b0, rsp_closing_point}, {31'b0, want.closing});
               check_field("last", {31'b0, rsp_last}, {31'b0, want.last});
            end
         end
         if (req_valid && !req_stall) begin
            decode_track_byte(req_data_byte, req_end_of_block,
                              req_end_of_block & req_end_of_track);
         end
      end
      fail_count <= errors;
      pending_count <= expected_points.size();
   end

endmodule

[tb/tb_saved_track_block_decoder_unit.sv]
// Top of the saved-track block decoder testbench: clock, reset, request traffic and verdict.
module tb_saved_track_block_decoder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 400000;
   localparam int RandomItems = 350;
   localparam int HoldCycles = 400;
   localparam int DrainCycles = 100;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_data_byte;
   logic               req_end_of_block;
   logic               req_end_of_track;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [24:0] rsp_latitude_raw;
   logic signed [24:0] rsp_longitude_raw;
   logic signed [31:0] rsp_elevation_q16;
   logic [31:0]        rsp_time_unix;
   logic               rsp_closing_point;
   logic               rsp_last;
   int                 fail_count;
   int                 pending_count;

   int                 cycle_count = 0;
   int                 sent_count = 0;
   int                 rsp_count = 0;
   bit                 send_idle = 1'b1;
   bit                 rsp_idle = 1'b0;
   bit                 rsp_long_hold = 1'b0;

   saved_track_block_decoder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_block  (req_end_of_block),
      .req_end_of_track  (req_end_of_track),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_latitude_raw  (rsp_latitude_raw),
      .rsp_longitude_raw (rsp_longitude_raw),
      .rsp_elevation_q16 (rsp_elevation_q16),
      .rsp_time_unix     (rsp_time_unix),
      .rsp_closing_point (rsp_closing_point),
      .rsp_last          (rsp_last)
   );

   saved_track_block_decoder_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_block  (req_end_of_block),
      .req_end_of_track  (req_end_of_track),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_latitude_raw  (rsp_latitude_raw),
      .rsp_longitude_raw (rsp_longitude_raw),
      .rsp_elevation_q16 (rsp_elevation_q16),
      .rsp_time_unix     (rsp_time_unix),
      .rsp_closing_point (rsp_closing_point),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("tb_saved_track_block_decoder_unit: FAIL");
         $finish;
      end
   end

   task automatic send_request(input logic [7:0] b, input logic eob, input logic eot);
      int gap;
      gap = send_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_block <= eob;
      req_end_of_track <= eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      if (sent_count % 40 == 0) begin
         send_idle = !send_idle;
      end
   endtask

   task automatic wait_for_results;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int  blocks;
      int  len;
      int  pick;
      bit  close_track;
      bit  held;
      bit  paused;
      logic [7:0] b;
      held = 1'b0;
      paused = 1'b0;
      req_valid <= 1'b0;
      req_data_byte <= 8'h00;
      req_end_of_block <= 1'b0;
      req_end_of_track <= 1'b0;
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // A one-byte track, then a track-end flag on a byte that does not close its block.
      send_request(8'hFF, 1'b1, 1'b1);
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'hFF, 1'b1, 1'b1);
      // Two records: fold boundary coordinates, wrapping time, extreme elevations.
      for (int i = 0; i < 25; i++) begin
         if (i < 2 || (i >= 8 && i <= 14)) begin
            b = 8'hFF;
         end else if (i == 4 || i == 7) begin
            b = 8'h80;
         end else if (i == 5) begin
            b = 8'h01;
         end else begin
            b = 8'h00;
         end
         send_request(b, i == 24, i == 24);
      end

      while (sent_count < RandomItems) begin
         blocks = $urandom_range(1, 3);
         close_track = ($urandom_range(0, 4) != 0);
         for (int blk = 0; blk < blocks; blk++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               len = $urandom_range(85, 110);
            end else if (pick < 3) begin
               len = $urandom_range(1, 12);
            end else begin
               len = $urandom_range(13, 50);
            end
            for (int i = 0; i < len; i++) begin
               if (i == len - 1) begin
                  send_request(8'($urandom), 1'b1, close_track && blk == blocks - 1);
               end else begin
                  send_request(8'($urandom), 1'b0, $urandom_range(0, 7) == 0);
               end
            end
            if (!held && sent_count >= 120) begin
               rsp_long_hold = 1'b1;
               held = 1'b1;
            end
            if (!paused && sent_count >= 250) begin
               wait_for_results();
               paused = 1'b1;
            end
         end
      end

      wait_for_results();
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_saved_track_block_decoder_unit: PASS");
      end else begin
         $display("tb_saved_track_block_decoder_unit: FAIL");
      end
      $finish;
   end

   initial begin
      int w;
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_long_hold && !hold_done) begin
            hold_done = 1'b1;
            w = HoldCycles;
         end else begin
            w = rsp_idle ? $urandom_range(0, 7) : 0;
         end
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         rsp_count++;
         if (rsp_count % 25 == 0) begin
            rsp_idle = !rsp_idle;
         end
      end
   end

endmodule
